// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside of reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant does not hold");
// When the condition holds, the property must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: follow-up property does not hold");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/core/swec_pkg.sv =====
// ----------------------------------------------------------------------------
// swec_pkg
// Types and constants shared by the sliding-window event counter.
// ----------------------------------------------------------------------------
`default_nettype none

package swec_pkg;

   localparam int FUNC_W  = 2;
   localparam int TIME_W  = 64;
   localparam int LEN_W   = 31;
   localparam int COUNT_W = 32;
   localparam int PROD_W  = COUNT_W + LEN_W;
   localparam int STEP_W  = $clog2(COUNT_W);

   localparam logic [FUNC_W-1:0] FUNC_RECORD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 31'd1000;
   localparam logic [LEN_W-1:0] LEN_MIN   = 31'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/swec_req_if.sv =====
// ----------------------------------------------------------------------------
// swec_req_if
// Request channel: one operation word with its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface swec_req_if;
   logic                              valid;
   logic                              ready;
   logic [swec_pkg::FUNC_W-1:0]       func;
   logic signed [swec_pkg::TIME_W-1:0] now_time;

   modport source (output valid, output func, output now_time, input ready);
   modport sink   (input valid, input func, input now_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swec_rsp_if.sv =====
// ----------------------------------------------------------------------------
// swec_rsp_if
// Response channel: the effective count and the rotation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swec_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [swec_pkg::COUNT_W-1:0] effective_count;
   logic                         rotated;

   modport source (output valid, output effective_count, output rotated, input ready);
   modport sink   (input valid, input effective_count, input rotated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sliding_window_event_counter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_event_counter
// Two-bucket sliding-window event counter with a time-weighted answer.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake       Contents
//   req       in    valid/ready     func, now_time
//   rsp       out   valid/ready     effective_count, rotated
//   csr       in    write enable    window_length (31 bits), no read-back
//
// A word is accepted only in the idle state; the next one is taken once it
// has passed subtract, clamp, multiply and divider launch, the serial
// divider (32 quotient bits), and the final add and response load. The
// divider is the longest step; the response load waits while the output stalls.
// Reset is synchronous and active high; it clears the counts and the window
// start and sets the window length to 1000.
// A stalled response register holds the finished word; the next request is
// taken while it waits, and its own result waits in the output state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sliding_window_event_counter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   swec_req_if.sink                         req_port,
   swec_rsp_if.source                       rsp_port,
   input  wire logic                        csr_we,
   input  wire logic [swec_pkg::LEN_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_CLAMP,
      S_MUL,
      S_DIVGO,
      S_DIVWAIT,
      S_OUT
   } state_type;

   localparam int DIFF_W = swec_pkg::TIME_W + 1;

   state_type                       state_ff, state_in;

   // Architectural state.
   logic [swec_pkg::LEN_W-1:0]      window_length_ff, window_length_in;
   logic [swec_pkg::TIME_W-1:0]     window_start_ff, window_start_in;
   logic [swec_pkg::COUNT_W-1:0]    current_events_ff, current_events_in;
   logic [swec_pkg::COUNT_W-1:0]    previous_events_ff, previous_events_in;

   // Per-word working registers.
   logic [swec_pkg::FUNC_W-1:0]     func_ff, func_in;
   logic [swec_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [DIFF_W-1:0]               diff_ff, diff_in;
   logic [swec_pkg::LEN_W-1:0]      remain_ff, remain_in;
   logic [swec_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                            rot_ff, rot_in;

   // Response register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [swec_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                            rsp_rot_ff, rsp_rot_in;

   logic                            div_start;
   swec_pkg::div_stat_type          div_stat;
   logic [swec_pkg::COUNT_W-1:0]    div_quot;

   logic                            req_take;
   logic                            behind;
   logic                            reached;
   logic                            rsp_free;
   logic [swec_pkg::COUNT_W:0]      sum;

   assign req_take = req_port.valid && req_port.ready;
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   // The difference is one bit wider than a timestamp, so it never wraps.
   // A negative difference means the word is older than the window start.
   assign behind  = diff_ff[DIFF_W-1];
   assign reached = !behind && (diff_ff[swec_pkg::TIME_W-1:0]
                    >= {{(swec_pkg::TIME_W - swec_pkg::LEN_W){1'b0}}, window_length_ff});

   assign sum = {1'b0, current_events_ff} + {1'b0, div_quot};

   assign div_start = (state_ff == S_DIVGO);

   always_comb begin
      state_in           = state_ff;
      window_length_in   = window_length_ff;
      window_start_in    = window_start_ff;
      current_events_in  = current_events_ff;
      previous_events_in = previous_events_ff;
      func_in            = func_ff;
      now_in             = now_ff;
      diff_in            = diff_ff;
      remain_in          = remain_ff;
      prod_in            = prod_ff;
      rot_in             = rot_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_port.ready;
      rsp_count_in       = rsp_count_ff;
      rsp_rot_in         = rsp_rot_ff;

      // A zero length would make the division meaningless, so it reads as one.
      if (csr_we) begin
         window_length_in = (csr_wdata == '0) ? swec_pkg::LEN_MIN : csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in  = req_port.func;
               now_in   = req_port.now_time;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = {now_ff[swec_pkg::TIME_W-1], now_ff}
                     - {window_start_ff[swec_pkg::TIME_W-1], window_start_ff};
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            // Update the counters, then find the part of the window still to
            // run at this word's time. After a rotation or a restart the window
            // starts now, so the whole length remains.
            rot_in = 1'b0;
            if (func_ff == swec_pkg::FUNC_RECORD && reached) begin
               previous_events_in = current_events_ff;
               current_events_in  = swec_pkg::COUNT_W'(1);
               window_start_in    = now_ff;
               rot_in             = 1'b1;
               remain_in          = window_length_ff;
            end else if (func_ff == swec_pkg::FUNC_RESTART) begin
               previous_events_in = '0;
               current_events_in  = '0;
               window_start_in    = now_ff;
               remain_in          = window_length_ff;
            end else begin
               if (func_ff == swec_pkg::FUNC_RECORD && current_events_ff != '1) begin
                  current_events_in = current_events_ff + 1'b1;
               end
               if (behind) begin
                  remain_in = window_length_ff;
               end else if (reached) begin
                  remain_in = '0;
               end else begin
                  remain_in = window_length_ff - diff_ff[swec_pkg::LEN_W-1:0];
               end
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = swec_pkg::PROD_W'(previous_events_ff) * swec_pkg::PROD_W'(remain_ff);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // The weighted term never exceeds the previous count, but the sum
            // with the current count can pass the top and then saturates.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = sum[swec_pkg::COUNT_W] ? '1 : sum[swec_pkg::COUNT_W-1:0];
               rsp_rot_in   = rot_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         window_length_ff   <= swec_pkg::LEN_RESET;
         window_start_ff    <= '0;
         current_events_ff  <= '0;
         previous_events_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         window_length_ff   <= window_length_in;
         window_start_ff    <= window_start_in;
         current_events_ff  <= current_events_in;
         previous_events_ff <= previous_events_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      func_ff      <= func_in;
      now_ff       <= now_in;
      diff_ff      <= diff_in;
      remain_ff    <= remain_in;
      prod_ff      <= prod_in;
      rot_ff       <= rot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rot_ff   <= rsp_rot_in;
   end

   swec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (window_length_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.effective_count = rsp_count_ff;
   assign rsp_port.rotated         = rsp_rot_ff;

   `ASSERT_HOLDS(top_div_start_idle, clock, reset, !(div_start && div_stat.busy))
   `ASSERT_HOLDS(top_quot_bounded, clock, reset,
                 (state_ff != S_OUT) || (div_quot <= previous_events_ff))
   `ASSERT_NEXT(top_rotation_update, clock, reset,
                (state_ff == S_CLAMP) && (func_ff == swec_pkg::FUNC_RECORD) && reached,
                rot_ff && (current_events_ff == swec_pkg::COUNT_W'(1))
                && (window_start_ff == now_ff))

endmodule

`default_nettype wire

// ===== rtl/core/swec_div.sv =====
// ----------------------------------------------------------------------------
// swec_div
// Serial restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in COUNT_W bits, so the upper dividend bits are
// already below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swec_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [swec_pkg::PROD_W-1:0]  dividend,
   input  wire logic [swec_pkg::LEN_W-1:0]   divisor,
   output swec_pkg::div_stat_type            stat,
   output logic [swec_pkg::COUNT_W-1:0]      quotient
);

   localparam logic [swec_pkg::STEP_W-1:0] LAST_STEP = swec_pkg::STEP_W'(swec_pkg::COUNT_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [swec_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [swec_pkg::LEN_W-1:0]    rem_ff, rem_in;
   logic [swec_pkg::COUNT_W-1:0]  quo_ff, quo_in;

   logic [swec_pkg::LEN_W:0]      trial;
   logic                          fits;

   // The partial remainder stays below the divisor, so one shifted-in bit
   // makes it at most one bit wider.
   assign trial = {rem_ff, quo_ff[swec_pkg::COUNT_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[swec_pkg::PROD_W-1:swec_pkg::COUNT_W];
         quo_in  = dividend[swec_pkg::COUNT_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? swec_pkg::LEN_W'(trial - {1'b0, divisor})
                       : trial[swec_pkg::LEN_W-1:0];
         quo_in = {quo_ff[swec_pkg::COUNT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   `ASSERT_HOLDS(div_rem_below_divisor, clock, reset, !busy_ff || (rem_ff < divisor))
   `ASSERT_NEXT(div_done_after_last, clock, reset,
                busy_ff && !start && (cnt_ff == LAST_STEP),
                done_ff && !busy_ff)

endmodule

`default_nettype wire
